FILE: hw/rtl/lru_page_replacement_assert.svh
// assertion macros for the lru page replacement block
`ifndef LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define LRU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define LRU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/lru_pkg.sv
// shared constants and types for the lru page replacement block
package lru_pkg;

  localparam int FRAME_SLOTS_DEF = 8;
  localparam int AGE_BITS_DEF    = 16;

  // page space is the full 8-bit page field, so no folding of the page number
  localparam int PAGE_BITS = 8;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // register index (paddr bit 2)
  localparam logic [0:0] REG_FRAMES_IN_USE = 1'b0;

  localparam logic [3:0] FRAMES_IN_USE_RST = 4'd8;

  // search token flags walking down the cell chain
  typedef struct packed {
    logic valid;
    logic hit;
    logic best_found;
  } tok_ctl_t;

endpackage

FILE: hw/rtl/lru_cell.sv
// one frame cell: page, age, and one step of the hit and oldest search
module lru_cell #(
  parameter int IDX      = 0,
  parameter int IDX_W    = 3,
  parameter int AGE_BITS = lru_pkg::AGE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           filled,
  input  lru_pkg::tok_ctl_t              in_ctl,
  input  logic [lru_pkg::PAGE_BITS-1:0]  in_page,
  input  logic [IDX_W-1:0]               in_hit_idx,
  input  logic [IDX_W-1:0]               in_best_idx,
  input  logic [AGE_BITS-1:0]            in_best_age,
  input  logic [lru_pkg::PAGE_BITS-1:0]  in_best_page,
  output lru_pkg::tok_ctl_t              out_ctl,
  output logic [lru_pkg::PAGE_BITS-1:0]  out_page,
  output logic [IDX_W-1:0]               out_hit_idx,
  output logic [IDX_W-1:0]               out_best_idx,
  output logic [AGE_BITS-1:0]            out_best_age,
  output logic [lru_pkg::PAGE_BITS-1:0]  out_best_page,
  input  logic                           wr_en,
  input  logic [IDX_W-1:0]               wr_idx,
  input  logic [lru_pkg::PAGE_BITS-1:0]  wr_page
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [lru_pkg::PAGE_BITS-1:0] page;
  logic [AGE_BITS-1:0]           age;
  logic [AGE_BITS-1:0]           age_inc;
  logic                          hit_here;
  logic                          take_best;
  lru_pkg::tok_ctl_t             ctl_next;

  // saturating age step
  assign age_inc   = (age == {AGE_BITS{1'b1}}) ? age : age + 1'b1;
  assign hit_here  = filled && (page == in_page);
  // strict compare keeps the lowest index on ties
  assign take_best = filled && (!in_ctl.best_found || (age_inc > in_best_age));

  always_comb begin
    ctl_next            = in_ctl;
    ctl_next.hit        = in_ctl.hit || hit_here;
    ctl_next.best_found = in_ctl.best_found || take_best;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    out_page      <= in_page;
    out_hit_idx   <= in_ctl.hit ? in_hit_idx : MY_IDX;
    out_best_idx  <= take_best ? MY_IDX : in_best_idx;
    out_best_age  <= take_best ? age_inc : in_best_age;
    out_best_page <= take_best ? page : in_best_page;
  end

  // aging as the token passes, write-back from the controller on commit
  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == MY_IDX)) begin
      page <= wr_page;
      age  <= '0;
    end else if (in_ctl.valid && filled) begin
      age <= age_inc;
    end
  end

endmodule

FILE: hw/rtl/lru_page_replacement.sv
// top level of the lru page replacement block: cell chain, control and config port
//
// Keeps up to FRAME_SLOTS resident pages, each in a cell of a chain that holds
// the page number and a saturating age. Each request (page_number,
// end_of_sequence) launches a search token into cell 0; the token steps one
// cell per clock, aging every filled frame it passes, noting the first frame
// whose page matches and the oldest frame so far (lowest index on ties). When
// the token leaves the last cell the controller picks the frame: the hit frame,
// else the next free frame while fewer than frames_in_use are filled, else the
// oldest frame, whose page is reported as evicted. The chosen frame is then
// written back (page, age cleared) and the result is loaded into the
// output register. A new request is taken only while the controller is
// idle, not during a search or commit, and the commit waits while the
// previous result is still stalled in the output register. With
// end_of_sequence set, the table is emptied and the fault count cleared
// after the result is formed. Config register frames_in_use sits at byte
// address 0 (0 acts as 1, values above FRAME_SLOTS act as FRAME_SLOTS);
// write it only while the block is idle.
`include "lru_page_replacement_assert.svh"

module lru_page_replacement #(
  parameter int FRAME_SLOTS = lru_pkg::FRAME_SLOTS_DEF,
  parameter int AGE_BITS    = lru_pkg::AGE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic [lru_pkg::PAGE_BITS-1:0]   page_number,
  input  logic                            end_of_sequence,
  // result channel
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic                            hit,
  output logic [2:0]                      frame_index,
  output logic                            evicted_valid,
  output logic [lru_pkg::PAGE_BITS-1:0]   evicted_page,
  output logic [31:0]                     fault_count,
  // config port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lru_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [lru_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [lru_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int IDX_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int CNT_W = $clog2(FRAME_SLOTS + 1);
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
  localparam int PB    = lru_pkg::PAGE_BITS;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  // control state
  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CNT_W-1:0] frames_filled;
  logic [31:0]      faults_seen;
  logic [3:0]       frames_in_use;

  // captured request and search outcome
  logic             eos_q;
  logic [PB-1:0]    page_q;
  logic             sr_hit;
  logic [IDX_W-1:0] sr_hit_idx;
  logic [IDX_W-1:0] sr_best_idx;
  logic [PB-1:0]    sr_best_page;

  // token chain taps, entry k feeds cell k
  lru_pkg::tok_ctl_t   tok_ctl       [FRAME_SLOTS+1];
  logic [PB-1:0]       tok_page      [FRAME_SLOTS+1];
  logic [IDX_W-1:0]    tok_hit_idx   [FRAME_SLOTS+1];
  logic [IDX_W-1:0]    tok_best_idx  [FRAME_SLOTS+1];
  logic [AGE_BITS-1:0] tok_best_age  [FRAME_SLOTS+1];
  logic [PB-1:0]       tok_best_page [FRAME_SLOTS+1];

  logic req_accept;
  logic commit;
  logic cfg_write;
  logic [CMP_W-1:0] limit;
  logic [CMP_W-1:0] cfg_w;
  logic room;
  logic [IDX_W-1:0] slot;
  logic ev_valid;
  logic [PB-1:0] ev_page;
  logic [31:0] faults_upd;
  logic [CNT_W-1:0] filled_upd;

  assign req_stall  = (state != S_IDLE);
  assign req_accept = req_valid && !req_stall;
  // commit once the output register is free or being emptied
  assign commit     = (state == S_COMMIT) && (!res_valid || !res_stall);

  // token entering cell 0
  assign tok_ctl[0]       = '{valid: req_accept, hit: 1'b0, best_found: 1'b0};
  assign tok_page[0]      = page_number;
  assign tok_hit_idx[0]   = '0;
  assign tok_best_idx[0]  = '0;
  assign tok_best_age[0]  = '0;
  assign tok_best_page[0] = '0;

  for (genvar i = 0; i < FRAME_SLOTS; i++) begin : g_cell
    logic cell_filled;
    // frames are filled in index order, so the count tells which are live
    assign cell_filled = (frames_filled > CNT_W'(i));

    lru_cell #(
      .IDX      (i),
      .IDX_W    (IDX_W),
      .AGE_BITS (AGE_BITS)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .filled        (cell_filled),
      .in_ctl        (tok_ctl[i]),
      .in_page       (tok_page[i]),
      .in_hit_idx    (tok_hit_idx[i]),
      .in_best_idx   (tok_best_idx[i]),
      .in_best_age   (tok_best_age[i]),
      .in_best_page  (tok_best_page[i]),
      .out_ctl       (tok_ctl[i+1]),
      .out_page      (tok_page[i+1]),
      .out_hit_idx   (tok_hit_idx[i+1]),
      .out_best_idx  (tok_best_idx[i+1]),
      .out_best_age  (tok_best_age[i+1]),
      .out_best_page (tok_best_page[i+1]),
      .wr_en         (commit),
      .wr_idx        (slot),
      .wr_page       (page_q)
    );
  end

  // frame limit from the config register, clamped to 1..FRAME_SLOTS
  assign cfg_w = CMP_W'(frames_in_use);
  always_comb begin
    priority if (cfg_w == '0) begin
      limit = CMP_W'(1);
    end else if (cfg_w > CMP_W'(FRAME_SLOTS)) begin
      limit = CMP_W'(FRAME_SLOTS);
    end else begin
      limit = cfg_w;
    end
  end
  assign room = (CMP_W'(frames_filled) < limit);

  // frame choice and counter updates for the request in hand
  always_comb begin
    slot       = sr_hit_idx;
    ev_valid   = 1'b0;
    ev_page    = '0;
    faults_upd = faults_seen;
    filled_upd = frames_filled;
    if (!sr_hit) begin
      // saturating fault count
      if (faults_seen != 32'hFFFF_FFFF) begin
        faults_upd = faults_seen + 32'd1;
      end
      if (room) begin
        slot       = IDX_W'(frames_filled);
        filled_upd = frames_filled + 1'b1;
      end else begin
        // full (or limit lowered below the fill): replace the oldest
        slot     = sr_best_idx;
        ev_valid = 1'b1;
        ev_page  = sr_best_page;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_accept) state_next = S_SEARCH;
      end
      S_SEARCH: begin
        if (tok_ctl[FRAME_SLOTS].valid) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (commit) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture request flags and the search outcome at the chain end
  always_ff @(posedge clk) begin
    if (req_accept) begin
      eos_q  <= end_of_sequence;
      page_q <= page_number;
    end
    if ((state == S_SEARCH) && tok_ctl[FRAME_SLOTS].valid) begin
      sr_hit       <= tok_ctl[FRAME_SLOTS].hit;
      sr_hit_idx   <= tok_hit_idx[FRAME_SLOTS];
      sr_best_idx  <= tok_best_idx[FRAME_SLOTS];
      sr_best_page <= tok_best_page[FRAME_SLOTS];
    end
  end

  // fill count and fault count, cleared after an end-of-sequence request
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_filled <= '0;
      faults_seen   <= '0;
    end else if (commit) begin
      frames_filled <= eos_q ? '0 : filled_upd;
      faults_seen   <= eos_q ? '0 : faults_upd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (commit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      hit           <= sr_hit;
      frame_index   <= 3'(slot);
      evicted_valid <= ev_valid;
      evicted_page  <= ev_page;
      fault_count   <= faults_upd;
    end
  end

  // config port, one register, zero wait states
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lru_pkg::FRAMES_IN_USE_RST;
    end else if (cfg_write && (paddr[2] == lru_pkg::REG_FRAMES_IN_USE)) begin
      frames_in_use <= pwdata[3:0];
    end
  end

  assign prdata = (paddr[2] == lru_pkg::REG_FRAMES_IN_USE) ?
                  {28'd0, frames_in_use} : '0;

  // checks
  `LRU_ASSERT_NOW(a_fill_bound, 1'b1, frames_filled <= CNT_W'(FRAME_SLOTS), "fill count past frame count")
  `LRU_ASSERT_NEXT(a_accept_search, req_accept, state == S_SEARCH, "accepted request did not start search")
  `LRU_ASSERT_NOW(a_token_in_search, tok_ctl[FRAME_SLOTS].valid, state == S_SEARCH, "token left chain outside search")
  `LRU_ASSERT_NOW(a_hit_no_evict, res_valid && hit, !evicted_valid && (evicted_page == '0), "hit reported an eviction")

endmodule
